// File: rtl/pnmhp_pkg.sv
`default_nettype none

package pnmhp_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned ValueW  = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned LimitW  = 63;
  localparam int unsigned PitchW  = 17;
  localparam int unsigned AreaW   = 2 * ValueW;

  localparam logic [LimitW-1:0] SIZE_LIMIT_RESET = 63'h7FFF_FFFF_FFFF_FFFD;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd2;

  // Token counter values: number of tokens begun so far
  localparam logic [1:0] TOK_WIDTH  = 2'd1;
  localparam logic [1:0] TOK_HEIGHT = 2'd2;
  localparam logic [1:0] TOK_MAXVAL = 2'd3;

  // Characters of interest
  localparam logic [DataW-1:0] CH_HASH    = 8'h23;
  localparam logic [DataW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [DataW-1:0] CH_SPACE   = 8'h20;
  localparam logic [DataW-1:0] CH_TAB     = 8'h09;
  localparam logic [DataW-1:0] CH_CR      = 8'h0D;
  localparam logic [AccW-1:0]  CH_ZERO    = 32'h0000_0030;

  localparam logic [ValueW-1:0] WIDE_SAMPLE = 16'd255;

  typedef struct packed {
    logic              in_comment;
    logic              in_token;
    logic [1:0]        token_index;
    logic [AccW-1:0]   accumulator;
    logic [ValueW-1:0] held_width;
    logic [ValueW-1:0] held_height;
    logic [AreaW-1:0]  held_area;
    logic              finished;
  } parse_state_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ValueW-1:0] width;
    logic [ValueW-1:0] height;
    logic [ValueW-1:0] max_value;
    logic [1:0]        bytes_per_sample;
    logic [PitchW-1:0] row_pitch;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/pnmhp_in_if.sv
`default_nettype none

interface pnmhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

`default_nettype wire

// File: rtl/pnmhp_out_if.sv
`default_nettype none

interface pnmhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] max_value;
  logic [1:0]  bytes_per_sample;
  logic [16:0] row_pitch;

  modport source (output valid, output status, output width, output height,
                  output max_value, output bytes_per_sample, output row_pitch,
                  input ready);
  modport sink   (input valid, input status, input width, input height,
                  input max_value, input bytes_per_sample, input row_pitch,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/pnmhp_step.sv
`default_nettype none

module pnmhp_step (
  input  pnmhp_pkg::parse_state_t     state_cur,
  input  logic [7:0]                  data_byte,
  input  logic                        first,
  input  logic [62:0]                 size_limit,
  output pnmhp_pkg::parse_state_t     state_nxt,
  output logic                        emit,
  output pnmhp_pkg::result_t          result
);
  import pnmhp_pkg::*;

  parse_state_t      base;
  logic              blank;
  logic [AccW-1:0]   acc_base;
  logic [AccW-1:0]   acc_next;
  logic [AccW-1:0]   val;
  logic              val_bad;
  logic              wide;
  logic [AreaW:0]    product;

  assign blank = (data_byte == CH_SPACE) ||
                 ((data_byte >= CH_TAB) && (data_byte <= CH_CR));

  assign acc_base = state_cur.in_token && !first ? state_cur.accumulator : '0;
  assign acc_next = {acc_base[AccW-4:0], 3'b000} + {acc_base[AccW-2:0], 1'b0}
                    + {{(AccW-DataW){1'b0}}, data_byte} - CH_ZERO;

  assign val     = base.accumulator;
  assign val_bad = (val == '0) || (val[AccW-1:ValueW] != '0);
  assign wide    = val[ValueW-1:0] > WIDE_SAMPLE;
  assign product = wide ? {base.held_area, 1'b0} : {1'b0, base.held_area};

  always_comb begin
    base = state_cur;
    if (first) begin
      base = '0;
    end
    state_nxt = base;
    emit      = 1'b0;
    result    = '0;

    if (base.finished) begin
      // drop everything until restart
    end else if (base.in_comment) begin
      if (data_byte == CH_NEWLINE) begin
        state_nxt.in_comment = 1'b0;
      end
    end else if (data_byte == CH_HASH) begin
      state_nxt.in_comment = 1'b1;
    end else if (!blank) begin
      if (!base.in_token) begin
        state_nxt.in_token    = 1'b1;
        state_nxt.token_index = base.token_index + 2'd1;
      end
      state_nxt.accumulator = acc_next;
    end else if (base.in_token) begin
      state_nxt.in_token    = 1'b0;
      state_nxt.accumulator = '0;
      if (val_bad || (base.token_index == 2'd0)) begin
        emit               = 1'b1;
        result.status      = STATUS_INVALID;
        state_nxt.finished = 1'b1;
      end else if (base.token_index == TOK_WIDTH) begin
        state_nxt.held_width = val[ValueW-1:0];
      end else if (base.token_index == TOK_HEIGHT) begin
        state_nxt.held_height = val[ValueW-1:0];
        state_nxt.held_area   = AreaW'(base.held_width) * AreaW'(val[ValueW-1:0]);
      end else begin
        // maxval closes the header
        emit                    = 1'b1;
        state_nxt.finished      = 1'b1;
        result.status           = ({{(LimitW-AreaW-1){1'b0}}, product} > size_limit)
                                  ? STATUS_TOO_BIG : STATUS_OK;
        result.width            = base.held_width;
        result.height           = base.held_height;
        result.max_value        = val[ValueW-1:0];
        result.bytes_per_sample = wide ? 2'd2 : 2'd1;
        result.row_pitch        = wide ? {base.held_width, 1'b0}
                                       : {1'b0, base.held_width};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pnm_header_field_parser_core.sv
`default_nettype none

// Channel   Direction  Word contents
// in_if     sink       data_byte[7:0], first (restart parser on this byte)
// out_if    source     status, width, height, max_value, bytes_per_sample, row_pitch
// cfg_*     write      size_limit[62:0], taken on any edge with cfg_we high
//
// One header byte per cycle while no result waits on a stalled out_if. A byte
// waits in the input register, and its result (if any) is loaded into the output
// register on the edge that consumes the byte, where out_if.valid rises; the
// earliest result handshake comes on the following edge.
// Reset clears the parser state and the valid flags and loads size_limit.
// A result waiting on out_if holds the input register; in_if.ready stays high
// whenever the input register is empty or will move on this edge.
module pnm_header_field_parser_core (
  input  logic              clk,
  input  logic              rst_n,
  pnmhp_in_if.sink          in_if,
  pnmhp_out_if.source       out_if,
  input  logic              cfg_we,
  input  logic [62:0]       cfg_data
);
  import pnmhp_pkg::*;

  // input register
  logic              in_valid_r;
  logic [DataW-1:0]  in_byte_r;
  logic              in_first_r;

  // parser state and size limit
  parse_state_t      state_r;
  parse_state_t      state_nxt;
  logic [LimitW-1:0] size_limit_r;

  // result register
  logic              out_valid_r;
  result_t           out_r;
  result_t           result_nxt;
  logic              emit;

  logic              out_free;
  logic              advance;
  logic              in_take;

  // The output register can take a new word if empty or draining this edge.
  assign out_free = !out_valid_r || out_if.ready;
  assign advance  = in_valid_r && out_free;
  assign in_if.ready = !in_valid_r || out_free;
  assign in_take  = in_if.valid && in_if.ready;

  pnmhp_step u_step (
    .state_cur  (state_r),
    .data_byte  (in_byte_r),
    .first      (in_first_r),
    .size_limit (size_limit_r),
    .state_nxt  (state_nxt),
    .emit       (emit),
    .result     (result_nxt)
  );

  // Input register: load on accept, otherwise empty once consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r  <= in_if.data_byte;
      in_first_r <= in_if.first;
    end
  end

  // Parser state moves only when the byte in the input register is consumed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_limit_r <= SIZE_LIMIT_RESET;
    end else if (cfg_we) begin
      size_limit_r <= cfg_data;
    end
  end

  // Output register: capture a result, drop the word once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_r <= result_nxt;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = out_r.status;
  assign out_if.width            = out_r.width;
  assign out_if.height           = out_r.height;
  assign out_if.max_value        = out_r.max_value;
  assign out_if.bytes_per_sample = out_r.bytes_per_sample;
  assign out_if.row_pitch        = out_r.row_pitch;

endmodule

`default_nettype wire

// File: tb/tb_pnm_header_field_parser_core.sv
`timescale 1ns / 100ps

module tb_pnm_header_field_parser_core;
  import pnmhp_pkg::*;

  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned SettleCycles  = 4;    // two pipeline registers, plus margin
  localparam int unsigned PhaseBytes    = 325;  // four phases, about 1300 words in all

  // One queued input word; drain holds it back until every expected result is out.
  typedef struct {
    logic [7:0] data;
    logic       first;
    bit         drain;
  } header_byte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [62:0] cfg_data;

  pnmhp_in_if  in_if ();
  pnmhp_out_if out_if ();

  pnm_header_field_parser_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  header_byte_t byte_queue[$];        // words waiting for the driver
  result_t      expected_headers[$];  // predicted result words, oldest first

  bit          first_next;   // flags for the next word pushed
  bit          hold_next;
  int unsigned idle_pct;     // sender idle chance, percent
  int unsigned stall_pct;    // receiver stall chance, percent
  bit          in_fire_q;    // input word taken at the last rising edge
  int unsigned cycle_count;
  int unsigned bytes_accepted;
  int unsigned headers_checked;
  int unsigned error_count;
  int unsigned status_count[3];

  // Parser state of the predictor, kept apart from the block
  logic        pr_in_comment;
  logic        pr_in_token;
  logic        pr_finished;
  logic [1:0]  pr_token_index;
  logic [31:0] pr_acc;
  logic [15:0] pr_width;
  logic [15:0] pr_height;
  logic [62:0] pr_size_limit;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_blank_byte(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // Clear the parser state; the size limit survives a restart.
  function automatic void clear_parser();
    pr_in_comment  = 1'b0;
    pr_in_token    = 1'b0;
    pr_finished    = 1'b0;
    pr_token_index = '0;
    pr_acc         = '0;
    pr_width       = '0;
    pr_height      = '0;
  endfunction

  // Advance the parser by one header byte; return 1 when it yields a result word.
  function automatic bit parse_header_byte(input logic [7:0] b, input logic first,
                                           output result_t res);
    logic [31:0] value;
    logic [1:0]  bps;
    logic [63:0] area;
    logic [17:0] pitch;
    res = '0;
    if (first)
      clear_parser();
    if (pr_finished)
      return 1'b0;
    // Skip comment bytes; the newline closes the comment and is swallowed with it.
    if (pr_in_comment) begin
      if (b == CH_NEWLINE)
        pr_in_comment = 1'b0;
      return 1'b0;
    end
    if (b == CH_HASH) begin
      pr_in_comment = 1'b1;
      return 1'b0;
    end
    // Any non-blank byte is a digit worth (byte - '0'), wrapping at 32 bits.
    if (!is_blank_byte(b)) begin
      if (!pr_in_token) begin
        pr_in_token    = 1'b1;
        pr_acc         = '0;
        pr_token_index = pr_token_index + 2'd1;
      end
      pr_acc = pr_acc * 32'd10 + ({24'd0, b} - CH_ZERO);
      return 1'b0;
    end
    if (!pr_in_token)
      return 1'b0;
    // Blank closes the token.
    pr_in_token = 1'b0;
    value       = pr_acc;
    pr_acc      = '0;
    if (value == 32'd0 || value >= 32'd65536 || pr_token_index == 2'd0) begin
      res.status  = STATUS_INVALID;
      pr_finished = 1'b1;
      return 1'b1;
    end
    case (pr_token_index)
      TOK_WIDTH: begin
        pr_width = value[15:0];
        return 1'b0;
      end
      TOK_HEIGHT: begin
        pr_height = value[15:0];
        return 1'b0;
      end
      default: begin
        bps   = (value[15:0] > WIDE_SAMPLE) ? 2'd2 : 2'd1;
        area  = 64'(pr_width) * 64'(pr_height) * 64'(bps);
        pitch = 18'(pr_width) * 18'(bps);
        res.status           = (area > {1'b0, pr_size_limit}) ? STATUS_TOO_BIG : STATUS_OK;
        res.width            = pr_width;
        res.height           = pr_height;
        res.max_value        = value[15:0];
        res.bytes_per_sample = bps;
        res.row_pitch        = pitch[16:0];
        pr_finished          = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void compare_field(input string name, input logic [16:0] want,
                                        input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_header(input result_t got);
    result_t want;
    if (expected_headers.size() == 0) begin
      $display("%0t: unexpected result word: expected none, got status %0d width %0d",
               $time, got.status, got.width);
      error_count++;
      return;
    end
    want = expected_headers.pop_front();
    headers_checked++;
    status_count[want.status]++;
    compare_field("status", 17'(want.status), 17'(got.status));
    compare_field("width", 17'(want.width), 17'(got.width));
    compare_field("height", 17'(want.height), 17'(got.height));
    compare_field("max_value", 17'(want.max_value), 17'(got.max_value));
    compare_field("bytes_per_sample", 17'(want.bytes_per_sample), 17'(got.bytes_per_sample));
    compare_field("row_pitch", want.row_pitch, got.row_pitch);
  endtask

  // Sample both handshakes at the rising edge. Check the result word before
  // predicting the word taken on the same edge, so an early result cannot
  // match its own prediction.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    cycle_count++;
    if (!rst_n) begin
      in_fire_q = 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.status           = out_if.status;
        got.width            = out_if.width;
        got.height           = out_if.height;
        got.max_value        = out_if.max_value;
        got.bytes_per_sample = out_if.bytes_per_sample;
        got.row_pitch        = out_if.row_pitch;
        check_header(got);
      end
      in_fire_q = in_if.valid && in_if.ready;
      if (in_fire_q) begin
        bytes_accepted++;
        if (parse_header_byte(in_if.data_byte, in_if.first, want))
          expected_headers.push_back(want);
      end
    end
    if (cycle_count >= TimeoutCycles) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_headers.size());
      $display("** pnm_header_field_parser_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
      // Hold a word until it is taken; then advance or go idle.
      if (!in_if.valid || in_fire_q) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct &&
            !(byte_queue[0].drain && expected_headers.size() != 0)) begin
          in_if.valid     <= 1'b1;
          in_if.data_byte <= byte_queue[0].data;
          in_if.first     <= byte_queue[0].first;
          void'(byte_queue.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b);
    header_byte_t w;
    w.data  = b;
    w.first = first_next;
    w.drain = hold_next;
    byte_queue.push_back(w);
    first_next = 1'b0;
    hold_next  = 1'b0;
  endtask

  task automatic push_text(input string s, input bit restart);
    first_next = restart;
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_blank();
    int unsigned r;
    r = $urandom_range(0, 7);
    return (r < 5) ? CH_TAB + 8'(r) : CH_SPACE;
  endfunction

  // Weighted token value: mostly in range, with the edges and some wrap-around.
  function automatic longint unsigned pick_value();
    case ($urandom_range(0, 19))
      0:  return 0;
      1:  return 65536;
      2:  return 64'd4294967297;  // wraps to 1
      3:  return 1;
      4:  return 255;
      5:  return 256;
      6:  return 65535;
      7, 8, 9, 10, 11: return $urandom_range(1, 65535);
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  task automatic push_comment();
    logic [7:0] b;
    push_byte(CH_HASH);
    repeat ($urandom_range(0, 4)) begin
      b = 8'($urandom);
      if (b == CH_NEWLINE)
        b = CH_HASH;
      push_byte(b);
    end
    push_byte(CH_NEWLINE);
  endtask

  task automatic push_separator();
    repeat ($urandom_range(1, 3))
      push_byte(pick_blank());
    if ($urandom_range(0, 5) == 0) begin
      push_comment();
      if ($urandom_range(0, 1) == 1)
        push_byte(pick_blank());
    end
  endtask

  // Emit one decimal token; garble swaps a digit for some other non-blank byte.
  task automatic push_token(input bit garble);
    string      digits;
    logic [7:0] b;
    digits = $sformatf("%0d", pick_value());
    if ($urandom_range(0, 9) == 0)
      digits = {"00", digits};
    for (int i = 0; i < digits.len(); i++) begin
      b = digits[i];
      if (garble && $urandom_range(0, digits.len() - 1) == 0) begin
        b = 8'($urandom);
        if (is_blank_byte(b) || b == CH_HASH)
          b = "x";
      end
      push_byte(b);
      // Drop a comment into the token now and then; it must not split it.
      if (i != digits.len() - 1 && $urandom_range(0, 19) == 0)
        push_comment();
    end
  endtask

  // Queue one header: mostly well formed, some cut short or garbled, some noise.
  task automatic queue_random_header();
    int unsigned kind;
    int unsigned ntok;
    kind       = $urandom_range(0, 99);
    hold_next  = ($urandom_range(0, 11) == 0);
    first_next = 1'b1;
    if (kind >= 90) begin
      first_next = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 8))
        push_byte(8'($urandom));
      return;
    end
    if ($urandom_range(0, 4) == 0)
      push_separator();
    ntok = (kind >= 75) ? $urandom_range(1, 3) : 3;
    for (int t = 0; t < ntok; t++) begin
      push_token(kind >= 75 && $urandom_range(0, 2) == 0);
      if (t < ntok - 1 || kind < 75 || $urandom_range(0, 1) == 1)
        push_separator();
    end
    // Trailing junk; ignored once the header has finished.
    repeat ($urandom_range(0, 3))
      push_byte(8'($urandom));
  endtask

  // Wait until every queued word is taken and every expected result is out,
  // then let the pipeline settle for words that give no result.
  task automatic wait_idle();
    do
      @(posedge clk);
    while (byte_queue.size() != 0 || in_if.valid || expected_headers.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_size_limit(input logic [62:0] limit);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= limit;
    @(negedge clk);
    cfg_we   <= 1'b0;
    pr_size_limit = limit;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.first      = 1'b0;
    out_if.ready     = 1'b0;
    first_next       = 1'b0;
    hold_next        = 1'b0;
    idle_pct         = 0;
    stall_pct        = 0;
    in_fire_q        = 1'b0;
    cycle_count      = 0;
    bytes_accepted   = 0;
    headers_checked  = 0;
    error_count      = 0;
    status_count     = '{0, 0, 0};
    clear_parser();
    pr_size_limit = SIZE_LIMIT_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset size limit.
    // Comment inside the width token: width reads as 12; max 300 gives two-byte samples.
    push_text("1#c\n2 3 300\n", 1'b1);
    // Bytes after a result are ignored, extremes of the byte range among them.
    push_byte(8'hFF);
    push_byte(8'h00);
    // Zero token is an invalid value.
    push_text("0 ", 1'b1);
    // Header cut off with no trailing blank: no result, restart follows.
    push_text("5 5 5", 1'b1);
    wait_idle();

    // Size check at its boundary: 10*11*2 is too big, 10*10*2 just fits.
    write_size_limit(63'd200);
    push_text("10 11 256\n", 1'b1);
    push_text("10 10 256 ", 1'b1);

    // Random headers across four pacing phases, each with its own size limit.
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          write_size_limit('1);
        end
        1: begin
          idle_pct  = 46;
          stall_pct = 0;
          write_size_limit('0);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 46;
          write_size_limit(63'($urandom_range(0, 200000)));
        end
        default: begin
          idle_pct  = 27;
          stall_pct = 27;
          write_size_limit({29'd0, 2'($urandom_range(0, 3)), 32'($urandom)});
        end
      endcase
      while (byte_queue.size() < PhaseBytes)
        queue_random_header();
    end
    wait_idle();

    $display("Fed %0d header bytes over four pacing phases and checked %0d result words",
             bytes_accepted, headers_checked);
    $display("Results seen: %0d ok, %0d invalid value, %0d too big",
             status_count[0], status_count[1], status_count[2]);
    if (error_count == 0) begin
      $display("** pnm_header_field_parser_core: PASSED **");
    end else begin
      $display("** pnm_header_field_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
